// File: hdl/voxel_round_dedup_assert.svh
// Assertion macros used by voxel_round_dedup to check itself.
`ifndef VOXEL_ROUND_DEDUP_ASSERT_SVH
`define VOXEL_ROUND_DEDUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voxel_round_dedup: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voxel_round_dedup: next-cycle check failed");

`endif

// File: hdl/vrd_pkg.sv
`default_nettype none

package vrd_pkg;

   localparam int COORD_IN_W  = 24;
   localparam int COORD_OUT_W = 16;
   localparam int COUNT_OUT_W = 9;

   localparam logic CMD_POINT = 1'b0;
   localparam logic CMD_EOF   = 1'b1;

   localparam logic KIND_POINT   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPEND,
      S_SUMMARY
   } state_type;

   typedef struct packed {
      logic load_pt;
      logic rd;
      logic append;
      logic set_flag;
      logic load_sum;
   } ctrl_cmd_type;

   typedef struct packed {
      logic idx_lt_cnt;
      logic match;
      logic full;
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// File: hdl/vrd_ctrl.sv
`default_nettype none

module vrd_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_cmd,
   output logic                          req_tready,
   input  wire vrd_pkg::ctrl_status_type status,
   output vrd_pkg::ctrl_cmd_type         cmd
);
   import vrd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_cmd == CMD_EOF) begin
                  state_in = S_SUMMARY;
               end else begin
                  cmd.load_pt = 1'b1;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (status.match) begin
               state_in = S_IDLE;
            end else if (status.idx_lt_cnt) begin
               cmd.rd = 1'b1;
            end else if (status.full) begin
               cmd.set_flag = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            if (status.out_free) begin
               cmd.append = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SUMMARY: begin
            if (status.out_free) begin
               cmd.load_sum = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/vrd_dpath.sv
`default_nettype none

module vrd_dpath #(
   parameter int TABLE_DEPTH   = 256,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic signed [vrd_pkg::COORD_IN_W-1:0] x_in,
   input  wire logic signed [vrd_pkg::COORD_IN_W-1:0] y_in,
   input  wire logic signed [vrd_pkg::COORD_IN_W-1:0] z_in,
   input  wire vrd_pkg::ctrl_cmd_type                 cmd,
   output vrd_pkg::ctrl_status_type                   status,
   input  wire logic                                  out_ready,
   output logic                                       out_valid,
   output logic                                       out_kind,
   output logic                                       out_overflow,
   output logic signed [vrd_pkg::COORD_OUT_W-1:0]     x_out,
   output logic signed [vrd_pkg::COORD_OUT_W-1:0]     y_out,
   output logic signed [vrd_pkg::COORD_OUT_W-1:0]     z_out,
   output logic        [vrd_pkg::COUNT_OUT_W-1:0]     unique_count
);
   import vrd_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = 3 * COORD_OUT_W;
   localparam int MAG_W   = COORD_IN_W + 1;
   localparam int HALF_SH = (FRACTION_BITS > 0) ? FRACTION_BITS - 1 : 0;
   localparam logic [MAG_W-1:0] HALF =
      (FRACTION_BITS > 0) ? (MAG_W'(1) << HALF_SH) : '0;
   localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(32767);
   localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(32768);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   function automatic logic [COORD_OUT_W-1:0] snap(input logic signed [COORD_IN_W-1:0] v);
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] rnd;
      neg = v[COORD_IN_W-1];
      mag = neg ? (MAG_W'(0) - MAG_W'(v)) : MAG_W'(v);
      rnd = (mag + HALF) >> FRACTION_BITS;
      if (!neg && rnd > POS_LIMIT) begin
         snap = 16'h7fff;
      end else if (neg && rnd > NEG_LIMIT) begin
         snap = 16'h8000;
      end else if (neg) begin
         snap = COORD_OUT_W'(MAG_W'(0) - rnd);
      end else begin
         snap = rnd[COORD_OUT_W-1:0];
      end
   endfunction

   logic [ENTRY_W-1:0] voxel_table [TABLE_DEPTH];

   logic [ENTRY_W-1:0] pt_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_pend_ff;
   logic [CNT_W-1:0]   scan_idx_ff;
   logic [CNT_W-1:0]   entry_count_ff;
   logic [CNT_W-1:0]   entry_count_in;
   logic               dropped_ff;
   logic               dropped_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               out_kind_ff;
   logic               out_overflow_ff;
   logic [ENTRY_W-1:0] out_pt_ff;
   logic [COUNT_OUT_W-1:0] out_count_ff;
   logic [CNT_W-1:0]   count_inc;

   assign count_inc = entry_count_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load_pt) begin
         pt_ff <= {snap(x_in), snap(y_in), snap(z_in)};
      end
      if (cmd.rd) begin
         rd_data_ff <= voxel_table[scan_idx_ff[IDX_W-1:0]];
      end
      if (cmd.append) begin
         voxel_table[entry_count_ff[IDX_W-1:0]] <= pt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pt) begin
         scan_idx_ff <= '0;
      end else if (cmd.rd) begin
         scan_idx_ff <= scan_idx_ff + CNT_W'(1);
      end
   end

   always_comb begin
      entry_count_in = entry_count_ff;
      dropped_in     = dropped_ff;
      if (cmd.append) begin
         entry_count_in = count_inc;
      end
      if (cmd.set_flag) begin
         dropped_in = 1'b1;
      end
      if (cmd.load_sum) begin
         entry_count_in = '0;
         dropped_in     = 1'b0;
      end
      out_valid_in = out_valid_ff && !out_ready;
      if (cmd.append || cmd.load_sum) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff     <= 1'b0;
         entry_count_ff <= '0;
         dropped_ff     <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         rd_pend_ff     <= cmd.rd;
         entry_count_ff <= entry_count_in;
         dropped_ff     <= dropped_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         out_kind_ff     <= KIND_POINT;
         out_overflow_ff <= 1'b0;
         out_pt_ff       <= pt_ff;
         out_count_ff    <= COUNT_OUT_W'(count_inc);
      end else if (cmd.load_sum) begin
         out_kind_ff     <= KIND_SUMMARY;
         out_overflow_ff <= dropped_ff;
         out_pt_ff       <= '0;
         out_count_ff    <= COUNT_OUT_W'(entry_count_ff);
      end
   end

   assign status.idx_lt_cnt = scan_idx_ff < entry_count_ff;
   assign status.match      = rd_pend_ff && (rd_data_ff == pt_ff);
   assign status.full       = entry_count_ff >= DEPTH_CNT;
   assign status.out_free   = !out_valid_ff || out_ready;

   assign out_valid    = out_valid_ff;
   assign out_kind     = out_kind_ff;
   assign out_overflow = out_overflow_ff;
   assign x_out        = out_pt_ff[3*COORD_OUT_W-1:2*COORD_OUT_W];
   assign y_out        = out_pt_ff[2*COORD_OUT_W-1:COORD_OUT_W];
   assign z_out        = out_pt_ff[COORD_OUT_W-1:0];
   assign unique_count = out_count_ff;

endmodule

`default_nettype wire

// File: hdl/voxel_round_dedup.sv
// Per-frame deduplication of 3D points snapped to an integer grid.
// The req channel carries one word per item: tuser is the command (point or
// end of frame) and tdata the signed fixed-point x, y and z. Each coordinate
// is rounded to the nearest integer, halves away from zero, and saturated to
// 16 bits. A point not yet seen in the frame is stored and returned on the
// rsp channel; a duplicate returns nothing. A new point that finds the table
// full is dropped and marked for the next summary. An end-of-frame word
// returns the unique count and the drop mark, then empties the table.
// The table memory is read one entry per cycle. A new point is compared with
// every held entry in turn; once the scan ends and the rsp register is free,
// the point is stored, its result loaded into that register and the input
// freed. A point dropped on a full table, or a duplicate, frees the input as
// its scan ends. An end-of-frame word loads its result once the rsp register
// is free, then frees the input. One word is processed at a time; the next is
// accepted once the current one has finished, even while its result waits in
// the rsp register. When the receiver stalls, the result holds in that register
// and a second result waits until it drains. Reset clears the entry count, the
// drop mark and the rsp valid flag; the table memory needs no clearing pass.
`default_nettype none

module voxel_round_dedup #(
   parameter int TABLE_DEPTH   = 256,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // x_in, y_in, z_in
   input  wire logic [0:0]  req_tuser,  // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // x_out, y_out, z_out, unique_count, zero fill
   output logic [1:0]       rsp_tuser   // kind, overflow
);
   import vrd_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   logic                          out_kind;
   logic                          out_overflow;
   logic signed [COORD_OUT_W-1:0] x_out;
   logic signed [COORD_OUT_W-1:0] y_out;
   logic signed [COORD_OUT_W-1:0] z_out;
   logic        [COUNT_OUT_W-1:0] unique_count;

   vrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vrd_dpath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .x_in         (req_tdata[23:0]),
      .y_in         (req_tdata[47:24]),
      .z_in         (req_tdata[71:48]),
      .cmd          (cmd),
      .status       (status),
      .out_ready    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .out_kind     (out_kind),
      .out_overflow (out_overflow),
      .x_out        (x_out),
      .y_out        (y_out),
      .z_out        (z_out),
      .unique_count (unique_count)
   );

   assign rsp_tdata = {7'd0, unique_count, z_out, y_out, x_out};
   assign rsp_tuser = {out_overflow, out_kind};

`include "voxel_round_dedup_assert.svh"

   `VRD_ASSERT_SAME(a_append_room, clock, reset, cmd.append, !status.full && status.out_free)
   `VRD_ASSERT_SAME(a_summary_room, clock, reset, cmd.load_sum, status.out_free)
   `VRD_ASSERT_SAME(a_no_read_after_match, clock, reset, cmd.rd, !status.match)
   `VRD_ASSERT_NEXT(a_result_shown, clock, reset, cmd.append || cmd.load_sum, rsp_tvalid)

endmodule

`default_nettype wire
